// ===== src/fdv_pkg.sv =====
// ----------------------------------------------------------------------------
// fdv_pkg
// Types and constants shared by the finite difference velocity block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdv_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [31:0] VEL_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] VEL_MIN  = 32'h8000_0000;
  localparam logic [31:0] VEL_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic signed [31:0] sample_time;
    logic signed [31:0] sample_position;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_time;
    logic signed [31:0] point_position;
    logic signed [31:0] point_velocity;
    logic signed [31:0] velocity_min;
    logic signed [31:0] velocity_max;
    logic               end_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EMIT_DIFF,
    ST_WAIT_DIFF,
    ST_EMIT_LAST,
    ST_WAIT_LAST
  } fdv_state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
    logic emit_diff;
    logic emit_last;
    logic commit;
    logic clear;
  } fdv_cmd_t;

  typedef struct packed {
    logic have_held;
    logic last;
    logic div_done;
  } fdv_sts_t;

endpackage

`default_nettype wire

// ===== src/fdv_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdv_ctrl
// Sequencer: sample capture, divider steps, result hand-off and run end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdv_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire fdv_pkg::fdv_sts_t sts_i,
  output fdv_pkg::fdv_cmd_t     cmd_o
);
  import fdv_pkg::*;

  fdv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (sts_i.have_held) state_d = ST_DIV;
        else if (sts_i.last) state_d = ST_EMIT_LAST;
        else                 state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_EMIT_DIFF;
      end
      ST_EMIT_DIFF: state_d = ST_WAIT_DIFF;
      ST_WAIT_DIFF: begin
        if (!out_stall_i) state_d = sts_i.last ? ST_EMIT_LAST : ST_IDLE;
      end
      ST_EMIT_LAST: state_d = ST_WAIT_LAST;
      ST_WAIT_LAST: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep   = 1'b1;
        cmd_o.commit = !sts_i.have_held && !sts_i.last;
      end
      ST_DIV:       cmd_o.step      = 1'b1;
      ST_EMIT_DIFF: cmd_o.emit_diff = 1'b1;
      ST_WAIT_DIFF: begin
        out_valid_o  = 1'b1;
        cmd_o.commit = !out_stall_i && !sts_i.last;
      end
      ST_EMIT_LAST: cmd_o.emit_last = 1'b1;
      ST_WAIT_LAST: begin
        out_valid_o = 1'b1;
        cmd_o.clear = !out_stall_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/fdv_dp.sv =====
// ----------------------------------------------------------------------------
// fdv_dp
// Datapath: held point, restoring divider, saturation, min/max, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdv_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fdv_pkg::in_item_t in_data_i,
  input  wire fdv_pkg::fdv_cmd_t cmd_i,
  output fdv_pkg::fdv_sts_t      sts_o,
  output fdv_pkg::out_item_t     out_data_o
);
  import fdv_pkg::*;

  logic [31:0]      cur_t_q, cur_x_q, held_t_q, held_x_q;
  logic             cur_last_q;
  logic             have_held_q, started_q;
  logic [31:0]      vel_q, min_q, max_q;
  logic [31:0]      rem_q, quo_q, dvs_q;
  logic             neg_q, sat_q, zero_q;
  logic [CNT_W-1:0] cnt_q;
  out_item_t        out_q;

  logic [32:0] dt_w, dx_w, dx_abs_w;
  logic [31:0] dx_mag_w;
  logic [32:0] shifted_w, sub_w;
  logic        ge_w;
  logic [31:0] vel_w, trk_v_w, min_w, max_w;

  always_comb begin
    dt_w     = {cur_t_q[31], cur_t_q} - {held_t_q[31], held_t_q};
    dx_w     = {cur_x_q[31], cur_x_q} - {held_x_q[31], held_x_q};
    dx_abs_w = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
    dx_mag_w = dx_abs_w[31:0];

    shifted_w = {rem_q, quo_q[31]};
    ge_w      = shifted_w >= {1'b0, dvs_q};
    sub_w     = shifted_w - {1'b0, dvs_q};

    if (zero_q) begin
      vel_w = VEL_ZERO;
    end else if (sat_q) begin
      vel_w = neg_q ? VEL_MIN : VEL_MAX;
    end else if (neg_q) begin
      vel_w = (quo_q > VEL_MIN) ? VEL_MIN : (~quo_q + 32'd1);
    end else begin
      vel_w = quo_q[31] ? VEL_MAX : quo_q;
    end

    trk_v_w = cmd_i.emit_diff ? vel_w : vel_q;
    if (!started_q) begin
      min_w = trk_v_w;
      max_w = trk_v_w;
    end else begin
      min_w = ($signed(trk_v_w) < $signed(min_q)) ? trk_v_w : min_q;
      max_w = ($signed(trk_v_w) > $signed(max_q)) ? trk_v_w : max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_held_q <= 1'b0;
      started_q   <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.prep) cnt_q <= '0;
      else if (cmd_i.step) cnt_q <= cnt_q + CNT_W'(1);
      if (cmd_i.emit_diff || cmd_i.emit_last) started_q <= 1'b1;
      if (cmd_i.commit) have_held_q <= 1'b1;
      if (cmd_i.clear) begin
        have_held_q <= 1'b0;
        started_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_t_q    <= in_data_i.sample_time;
      cur_x_q    <= in_data_i.sample_position;
      cur_last_q <= in_data_i.last_sample;
      vel_q      <= VEL_ZERO;
    end
    if (cmd_i.prep) begin
      zero_q <= dt_w[32] || (dt_w == 33'd0);
      neg_q  <= dx_w[32];
      sat_q  <= {16'd0, dx_mag_w[31:16]} >= dt_w[31:0];
      dvs_q  <= dt_w[31:0];
      rem_q  <= {16'd0, dx_mag_w[31:16]};
      quo_q  <= {dx_mag_w[15:0], 16'd0};
    end
    if (cmd_i.step) begin
      rem_q <= ge_w ? sub_w[31:0] : shifted_w[31:0];
      quo_q <= {quo_q[30:0], ge_w};
    end
    if (cmd_i.emit_diff) begin
      vel_q                <= vel_w;
      out_q.point_time     <= held_t_q;
      out_q.point_position <= held_x_q;
      out_q.point_velocity <= vel_w;
      out_q.end_of_run     <= 1'b0;
    end
    if (cmd_i.emit_last) begin
      out_q.point_time     <= cur_t_q;
      out_q.point_position <= cur_x_q;
      out_q.point_velocity <= vel_q;
      out_q.end_of_run     <= 1'b1;
    end
    if (cmd_i.emit_diff || cmd_i.emit_last) begin
      min_q              <= min_w;
      max_q              <= max_w;
      out_q.velocity_min <= min_w;
      out_q.velocity_max <= max_w;
    end
    if (cmd_i.commit) begin
      held_t_q <= cur_t_q;
      held_x_q <= cur_x_q;
    end
  end

  assign sts_o.have_held = have_held_q;
  assign sts_o.last      = cur_last_q;
  assign sts_o.div_done  = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign out_data_o      = out_q;

endmodule

`default_nettype wire

// ===== src/finite_difference_velocity_top.sv =====
// ----------------------------------------------------------------------------
// finite_difference_velocity_top
// Forward-difference velocity of a Q16.16 (time, position) trajectory.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample that follows a held point goes
// through capture, set-up, 32 steps of the bit-serial restoring divider and
// result load before its result is offered, and the result then waits under
// out_stall_i; a final sample adds a second result load and one more result
// transaction. A first sample that is not final is captured and then made the
// held point in set-up. in_stall_o stays high while a sample is being worked on.
`timescale 1ns / 1ps
`default_nettype none

module finite_difference_velocity_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire fdv_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output fdv_pkg::out_item_t      out_data_o
);
  import fdv_pkg::*;

  fdv_cmd_t cmd;
  fdv_sts_t sts;

  fdv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fdv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("not busy after sample transaction");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.velocity_min) <= $signed(out_data_o.velocity_max)))
    else $error("velocity min above max");

  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.end_of_run) |=> !in_stall_o)
    else $error("not idle after end of run");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for finite_difference_velocity_top.
// ----------------------------------------------------------------------------
// A directed set of trajectories comes first. It covers a lone final sample,
// time that stands still or goes back, saturation at both ends, extreme times
// and truncation toward zero. Random trajectories follow, with some noise and
// some trajectories left open. A queue feeds the driver, and an in-bench
// predictor works out the expected points. The monitor checks every output
// transaction against the oldest of them. Both sides idle at random, and there
// is one long receiver hold-off.
`timescale 1ns / 1ps

module tb;
  import fdv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_AT     = 3000;
  localparam int unsigned HOLD_LEN    = 500;
  localparam int unsigned CALM_FROM   = 10000;
  localparam int unsigned CALM_TO     = 25000;
  localparam int unsigned DRAIN_WAIT  = 100;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  finite_difference_velocity_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  in_item_t    samples_to_send[$];
  out_item_t   expected_points[$];
  int unsigned fault_count = 0;
  int unsigned cycle       = 0;
  int unsigned hold_left   = 0;
  logic        calm;

  // predictor state
  logic signed [31:0] held_t, held_x, vel_lo, vel_hi;
  logic               have_held, stats_on;

  assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] slope_q16(logic signed [31:0] t0,
                                                   logic signed [31:0] x0,
                                                   logic signed [31:0] t1,
                                                   logic signed [31:0] x1);
    longint dt, dx, q;
    dt = longint'(t1) - longint'(t0);
    dx = longint'(x1) - longint'(x0);
    if (dt <= 0) return VEL_ZERO;
    q = (dx * 65536) / dt;
    if (q > 64'sd2147483647) return VEL_MAX;
    if (q < -64'sd2147483648) return VEL_MIN;
    return q[31:0];
  endfunction

  function automatic void note_velocity(logic signed [31:0] v);
    if (!stats_on) begin
      vel_lo   = v;
      vel_hi   = v;
      stats_on = 1'b1;
    end else begin
      if (v < vel_lo) vel_lo = v;
      if (v > vel_hi) vel_hi = v;
    end
  endfunction

  function automatic void predict_sample(in_item_t s);
    out_item_t          p;
    logic signed [31:0] v;
    v = VEL_ZERO;
    if (have_held) begin
      v = slope_q16(held_t, held_x, s.sample_time, s.sample_position);
      note_velocity(v);
      p.point_time     = held_t;
      p.point_position = held_x;
      p.point_velocity = v;
      p.velocity_min   = vel_lo;
      p.velocity_max   = vel_hi;
      p.end_of_run     = 1'b0;
      expected_points.push_back(p);
    end
    held_t    = s.sample_time;
    held_x    = s.sample_position;
    have_held = 1'b1;
    if (s.last_sample) begin
      note_velocity(v);
      p.point_time     = s.sample_time;
      p.point_position = s.sample_position;
      p.point_velocity = v;
      p.velocity_min   = vel_lo;
      p.velocity_max   = vel_hi;
      p.end_of_run     = 1'b1;
      expected_points.push_back(p);
      held_t    = '0;
      held_x    = '0;
      have_held = 1'b0;
      vel_lo    = '0;
      vel_hi    = '0;
      stats_on  = 1'b0;
    end
  endfunction

  function automatic void queue_sample(int t, int x, bit last);
    in_item_t s;
    s.sample_time     = t;
    s.sample_position = x;
    s.last_sample     = last;
    samples_to_send.push_back(s);
  endfunction

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("FAIL finite_difference_velocity_top");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_sample(in_data_i);
      if (samples_to_send.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= samples_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        fault_count++;
        $error("unexpected output transaction: time %0d", out_data_o.point_time);
      end else begin
        out_item_t e;
        e = expected_points.pop_front();
        if (out_data_o.point_time !== e.point_time) begin
          fault_count++;
          $error("point_time: expected %0d, got %0d", e.point_time, out_data_o.point_time);
        end
        if (out_data_o.point_position !== e.point_position) begin
          fault_count++;
          $error("point_position: expected %0d, got %0d",
                 e.point_position, out_data_o.point_position);
        end
        if (out_data_o.point_velocity !== e.point_velocity) begin
          fault_count++;
          $error("point_velocity: expected %0d, got %0d",
                 e.point_velocity, out_data_o.point_velocity);
        end
        if (out_data_o.velocity_min !== e.velocity_min) begin
          fault_count++;
          $error("velocity_min: expected %0d, got %0d", e.velocity_min, out_data_o.velocity_min);
        end
        if (out_data_o.velocity_max !== e.velocity_max) begin
          fault_count++;
          $error("velocity_max: expected %0d, got %0d", e.velocity_max, out_data_o.velocity_max);
        end
        if (out_data_o.end_of_run !== e.end_of_run) begin
          fault_count++;
          $error("end_of_run: expected %0d, got %0d", e.end_of_run, out_data_o.end_of_run);
        end
      end
    end
    if (cycle == HOLD_AT) hold_left <= HOLD_LEN;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall_i <= (hold_left != 0) || (!calm && $urandom_range(99) < 36);
  end

  // stimulus and end of run
  initial begin
    int t, x, len, step, dx;
    bit open_end;
    held_t    = '0;
    held_x    = '0;
    vel_lo    = '0;
    vel_hi    = '0;
    have_held = 1'b0;
    stats_on  = 1'b0;

    // lone final sample
    queue_sample(0, 0, 1);
    // steady slope, standing time, time going back, then the end
    queue_sample(0, 0, 0);
    queue_sample(65536, 65536, 0);
    queue_sample(131072, 0, 0);
    queue_sample(131072, 5, 0);
    queue_sample(65536, 7, 0);
    queue_sample(196608, 100, 1);
    // saturation high then low
    queue_sample(0, 32'sh8000_0000, 0);
    queue_sample(1, 32'sh7FFF_FFFF, 0);
    queue_sample(2, 32'sh8000_0000, 1);
    // widest time span
    queue_sample(32'sh8000_0000, 0, 0);
    queue_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    // truncation toward zero, both signs
    queue_sample(0, 0, 0);
    queue_sample(3, -1, 1);
    queue_sample(10, 0, 0);
    queue_sample(13, 1, 0);
    queue_sample(16, 0, 1);
    // final sample earlier than the held one
    queue_sample(100, 5, 0);
    queue_sample(50, 9, 1);

    while (samples_to_send.size() < 1600) begin
      if ($urandom_range(99) < 10) begin
        queue_sample($urandom, $urandom, $urandom_range(1));
      end else begin
        len      = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        open_end = ($urandom_range(19) == 0);
        t        = $urandom;
        x        = $urandom;
        for (int k = 0; k < len; k++) begin
          queue_sample(t, x, (k == len - 1) && !open_end);
          case ($urandom_range(9))
            0:       step = 0;
            1:       step = -$urandom_range(1, 1 << 16);
            2:       step = $urandom;
            3, 4:    step = $urandom_range(1, 16);
            default: step = $urandom_range(1, 1 << 20);
          endcase
          case ($urandom_range(7))
            0:       dx = $urandom;
            1, 2:    dx = $urandom_range(0, 1 << 24) - (1 << 23);
            default: dx = $urandom_range(0, 1 << 18) - (1 << 17);
          endcase
          t = t + step;
          x = x + dx;
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_to_send.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      fault_count++;
      $error("%0d expected transactions never arrived", expected_points.size());
    end
    if (fault_count == 0) begin
      $display("PASS finite_difference_velocity_top");
    end else begin
      $display("FAIL finite_difference_velocity_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fdv_pkg.sv
src/fdv_ctrl.sv
src/fdv_dp.sv
src/finite_difference_velocity_top.sv
tb/tb.sv
